### rtl/mpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_pkg
// Shared constants and types for the multichannel PID speed controller.
// ----------------------------------------------------------------------------
package mpsc_pkg;

    // number of motor channels with their own controller state
    localparam int CHANNELS = 4;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CH_W   = 2;   // channel field
    localparam int DATA_W = 16;  // setpoint, measured, gains
    localparam int ERR_W  = 17;  // setpoint - measured
    localparam int ACC_W  = 19;  // integral, Q10.8
    localparam int MAG_W  = 10;  // drive magnitude
    localparam int IDX_W  = 2;   // config register index

    // Q.8 limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = 19'sd255744;   //  999.0
    localparam logic signed [ACC_W-1:0] ACC_MIN = -19'sd255744;  // -999.0
    localparam logic signed [ACC_W-1:0] SAT_HI  = 19'sd256000;   // 1000.0

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2
    } t_reg_idx;

    // per-channel controller state as held in memory
    typedef struct packed {
        logic signed [ACC_W-1:0] integ;
        logic signed [ERR_W-1:0] last_err;
    } t_chan_state;

    localparam int STATE_W = $bits(t_chan_state);

endpackage

### rtl/multichannel_pid_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pid_speed_controller
// Per-channel PID speed loop with Q8.8 gains, integral clamp and saturated
// PWM drive output. Channel state lives in a small RAM.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  request   i_valid / o_stall, channel setpoint measured halt   in
//  result    o_valid / i_stall, channel_out reverse magnitude    out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                     in
//
//  one request per cycle sustained while i_stall is low; a result passes stages 1-5, then the output register
//  the state RAM is read one stage ahead of its read-modify-write stage; the
//  last write is forwarded so back-to-back ticks on one channel see fresh state
//  reset clears per-entry valid bits, unwritten entries read as zero
//  i_stall reaches o_stall combinationally through the stage enables; bubbles
//  are squeezed out
// ----------------------------------------------------------------------------
module multichannel_pid_speed_controller (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [mpsc_pkg::CH_W-1:0]              i_channel,
    input  logic signed [mpsc_pkg::DATA_W-1:0]     i_setpoint,
    input  logic signed [mpsc_pkg::DATA_W-1:0]     i_measured,
    input  logic                                   i_halt,
    // result
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [mpsc_pkg::CH_W-1:0]              o_channel_out,
    output logic                                   o_reverse,
    output logic [mpsc_pkg::MAG_W-1:0]             o_magnitude,
    // config
    input  logic                                   i_cfg_we,
    input  logic [mpsc_pkg::IDX_W-1:0]             i_cfg_idx,
    input  logic [mpsc_pkg::DATA_W-1:0]            i_cfg_data
);

    localparam int AW = mpsc_pkg::CH_AW;
    localparam int SW = mpsc_pkg::STATE_W;
    localparam int EW = mpsc_pkg::ERR_W;
    localparam int AC = mpsc_pkg::ACC_W;

    // gains
    logic [mpsc_pkg::DATA_W-1:0] r_prop_gain;
    logic [mpsc_pkg::DATA_W-1:0] r_integ_gain;
    logic [mpsc_pkg::DATA_W-1:0] r_deriv_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
        end else if (i_cfg_we) begin
            case (mpsc_pkg::t_reg_idx'(i_cfg_idx))
                mpsc_pkg::REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                mpsc_pkg::REG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                mpsc_pkg::REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables, back from the output register
    logic en_out, en5, en4, en3, en2, en1;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_out_vld;

    assign en_out = !r_out_vld || !i_stall;
    assign en5    = !r_s5_vld  || en_out;
    assign en4    = !r_s4_vld  || en5;
    assign en3    = !r_s3_vld  || en4;
    assign en2    = !r_s2_vld  || en3;
    assign en1    = !r_s1_vld  || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en1)    r_s1_vld  <= i_valid;
            if (en2)    r_s2_vld  <= r_s1_vld;
            if (en3)    r_s3_vld  <= r_s2_vld;
            if (en4)    r_s4_vld  <= r_s3_vld;
            if (en5)    r_s5_vld  <= r_s4_vld;
            if (en_out) r_out_vld <= r_s5_vld;
        end
    end

    // stage 1: error
    logic [mpsc_pkg::CH_W-1:0] r_s1_ch;
    logic                      r_s1_inr, r_s1_halt;
    logic signed [EW-1:0]      r_s1_err;
    logic signed [EW-1:0]      n_s1_err;

    assign n_s1_err = EW'(i_setpoint) - EW'(i_measured);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_ch   <= i_channel;
            r_s1_inr  <= (32'(i_channel) < mpsc_pkg::CHANNELS);
            r_s1_halt <= i_halt;
            r_s1_err  <= n_s1_err;
        end
    end

    // stage 2: P and I products, state read issued from stage 1
    logic signed [EW:0]        pg_s, ig_s, dg_s;
    logic signed [2*EW-1:0]    n_s2_p, n_s2_iprod;
    logic [mpsc_pkg::CH_W-1:0] r_s2_ch;
    logic                      r_s2_inr, r_s2_halt;
    logic signed [EW-1:0]      r_s2_err;
    logic signed [2*EW-1:0]    r_s2_p, r_s2_iprod;

    assign pg_s = {2'b00, r_prop_gain};
    assign ig_s = {2'b00, r_integ_gain};
    assign dg_s = {2'b00, r_deriv_gain};
    assign n_s2_p     = (2*EW)'(pg_s) * (2*EW)'(r_s1_err);
    assign n_s2_iprod = (2*EW)'(ig_s) * (2*EW)'(r_s1_err);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_ch    <= r_s1_ch;
            r_s2_inr   <= r_s1_inr;
            r_s2_halt  <= r_s1_halt;
            r_s2_err   <= r_s1_err;
            r_s2_p     <= n_s2_p;
            r_s2_iprod <= n_s2_iprod;
        end
    end

    // state memory with valid bits and last-write forwarding
    logic [AW-1:0]           s2_addr;
    logic [SW-1:0]           ram_rdata;
    logic                    ram_we;
    mpsc_pkg::t_chan_state   rd_state, n_wr_state;
    logic                    r_ent_vld [mpsc_pkg::CHANNELS];
    logic                    r_lw_vld;
    logic [AW-1:0]           r_lw_addr;
    mpsc_pkg::t_chan_state   r_lw_data;

    assign s2_addr = AW'(r_s2_ch);

    mpsc_ram #(
        .WIDTH (SW),
        .DEPTH (mpsc_pkg::CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s2_addr),
        .i_wdata (n_wr_state),
        .i_re    (en2),
        .i_raddr (AW'(r_s1_ch)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_lw_vld && (r_lw_addr == s2_addr)) begin
            rd_state = r_lw_data;
        end else if (r_ent_vld[s2_addr]) begin
            rd_state = mpsc_pkg::t_chan_state'(ram_rdata);
        end else begin
            rd_state = '0;
        end
    end

    // integral update and clamp
    logic signed [2*EW:0]    acc_sum;
    logic signed [AC-1:0]    n_s3_integ;
    logic signed [EW:0]      n_s3_derr;

    assign acc_sum = (2*EW+1)'(rd_state.integ) + (2*EW+1)'(r_s2_iprod);

    always_comb begin
        if (acc_sum > (2*EW+1)'(mpsc_pkg::ACC_MAX)) begin
            n_s3_integ = mpsc_pkg::ACC_MAX;
        end else if (acc_sum < (2*EW+1)'(mpsc_pkg::ACC_MIN)) begin
            n_s3_integ = mpsc_pkg::ACC_MIN;
        end else begin
            n_s3_integ = AC'(acc_sum);
        end
    end

    assign n_s3_derr = (EW+1)'(r_s2_err) - (EW+1)'(rd_state.last_err);

    always_comb begin
        if (r_s2_halt) begin
            n_wr_state = '0;
        end else begin
            n_wr_state.integ    = n_s3_integ;
            n_wr_state.last_err = r_s2_err;
        end
    end

    assign ram_we = r_s2_vld && en3 && r_s2_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_vld <= 1'b0;
            for (int k = 0; k < mpsc_pkg::CHANNELS; k++) begin
                r_ent_vld[k] <= 1'b0;
            end
        end else if (ram_we) begin
            r_lw_vld           <= 1'b1;
            r_ent_vld[s2_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_lw_addr <= s2_addr;
            r_lw_data <= n_wr_state;
        end
    end

    // stage 3: D product, P + I
    logic [mpsc_pkg::CH_W-1:0] r_s3_ch;
    logic                      r_s3_zero;
    logic signed [2*EW-1:0]    r_s3_p;
    logic signed [AC-1:0]      r_s3_integ;
    logic signed [EW:0]        r_s3_derr;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_ch    <= r_s2_ch;
            r_s3_zero  <= r_s2_halt || !r_s2_inr;
            r_s3_p     <= r_s2_p;
            r_s3_integ <= n_s3_integ;
            r_s3_derr  <= n_s3_derr;
        end
    end

    logic signed [2*EW:0] n_s4_d, n_s4_pi;

    assign n_s4_d  = (2*EW+1)'(dg_s) * (2*EW+1)'(r_s3_derr);
    assign n_s4_pi = (2*EW+1)'(r_s3_p) + (2*EW+1)'(r_s3_integ);

    // stage 4: sum and saturate
    logic [mpsc_pkg::CH_W-1:0] r_s4_ch;
    logic                      r_s4_zero;
    logic signed [2*EW:0]      r_s4_d, r_s4_pi;
    logic signed [2*EW+1:0]    sum;
    logic signed [AC-1:0]      n_s5_sat;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_ch   <= r_s3_ch;
            r_s4_zero <= r_s3_zero;
            r_s4_d    <= n_s4_d;
            r_s4_pi   <= n_s4_pi;
        end
    end

    assign sum = (2*EW+2)'(r_s4_pi) + (2*EW+2)'(r_s4_d);

    always_comb begin
        if (sum > (2*EW+2)'(mpsc_pkg::ACC_MAX)) begin
            n_s5_sat = mpsc_pkg::SAT_HI;
        end else if (sum < (2*EW+2)'(mpsc_pkg::ACC_MIN)) begin
            n_s5_sat = mpsc_pkg::ACC_MIN;
        end else begin
            n_s5_sat = AC'(sum);
        end
    end

    // stage 5: sign and magnitude
    logic [mpsc_pkg::CH_W-1:0] r_s5_ch;
    logic                      r_s5_zero;
    logic signed [AC-1:0]      r_s5_sat;
    logic [AC-1:0]             abs_sat;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_ch   <= r_s4_ch;
            r_s5_zero <= r_s4_zero;
            r_s5_sat  <= n_s5_sat;
        end
    end

    // truncation toward zero: take the magnitude first, then drop the fraction
    assign abs_sat = r_s5_sat[AC-1] ? AC'(-r_s5_sat) : AC'(r_s5_sat);

    logic [mpsc_pkg::CH_W-1:0]  r_out_ch;
    logic                       r_out_rev;
    logic [mpsc_pkg::MAG_W-1:0] r_out_mag;

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_ch  <= r_s5_ch;
            r_out_rev <= !r_s5_zero && r_s5_sat[AC-1];
            r_out_mag <= r_s5_zero ? '0 : abs_sat[8 +: mpsc_pkg::MAG_W];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_channel_out = r_out_ch;
    assign o_reverse     = r_out_rev;
    assign o_magnitude   = r_out_mag;

    // checks
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_magnitude <= 10'd1000))
        else $error("drive magnitude above 1000");

    a_rev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reverse) |-> (o_magnitude <= 10'd999))
        else $error("reverse drive above 999");

    a_integ_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> ((r_s3_integ <= mpsc_pkg::ACC_MAX) && (r_s3_integ >= mpsc_pkg::ACC_MIN)))
        else $error("integral outside clamp");

    a_fwd_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_lw_vld && r_ent_vld[r_lw_addr]))
        else $error("state write not marked valid");

endmodule

### rtl/mpsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/mpsc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_tb_pkg
// Drive predictor and result scoreboard for the PID speed controller bench.
// Each accepted request is run through a bit-accurate copy of the control
// law, and each result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
package mpsc_tb_pkg;

    localparam int FRAC_ONE   = 256;  // one unit in Q.8
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [mpsc_pkg::CH_W-1:0]  channel;
        logic                       reverse;
        logic [mpsc_pkg::MAG_W-1:0] magnitude;
    } t_drive;

    class pid_drive_scoreboard;
        int     prop_gain;
        int     integ_gain;
        int     deriv_gain;
        int     integ_acc [mpsc_pkg::CHANNELS];
        int     last_err  [mpsc_pkg::CHANNELS];
        t_drive drive_q[$];
        int     mismatches;
        int     ticks;
        int     halts;
        int     saturated;
        int     reversed;

        function new();
            prop_gain  = 0;
            integ_gain = 0;
            deriv_gain = 0;
            foreach (integ_acc[k]) begin
                integ_acc[k] = 0;
                last_err[k]  = 0;
            end
            mismatches = 0;
            ticks      = 0;
            halts      = 0;
            saturated  = 0;
            reversed   = 0;
        endfunction

        function void write_gain(logic [mpsc_pkg::IDX_W-1:0] idx,
                                 logic [mpsc_pkg::DATA_W-1:0] data);
            case (mpsc_pkg::t_reg_idx'(idx))
                mpsc_pkg::REG_PROP_GAIN:  prop_gain  = int'(data);
                mpsc_pkg::REG_INTEG_GAIN: integ_gain = int'(data);
                mpsc_pkg::REG_DERIV_GAIN: deriv_gain = int'(data);
                default: ;
            endcase
        endfunction

        // predicted drive for one accepted request, channel state updated
        function void note_tick(logic [mpsc_pkg::CH_W-1:0] ch,
                                logic signed [mpsc_pkg::DATA_W-1:0] sp,
                                logic signed [mpsc_pkg::DATA_W-1:0] pv, logic halt);
            logic signed [mpsc_pkg::ERR_W-1:0] err;
            longint e;
            longint p;
            longint d;
            longint acc;
            longint sum;
            t_drive want;
            want.channel   = ch;
            want.reverse   = 1'b0;
            want.magnitude = '0;
            ticks++;
            if (int'(ch) < mpsc_pkg::CHANNELS) begin
                if (halt) begin
                    integ_acc[ch] = 0;
                    last_err[ch]  = 0;
                    halts++;
                end else begin
                    err = sp - pv;
                    e   = err;
                    p   = longint'(prop_gain) * e;
                    d   = longint'(deriv_gain) * (e - longint'(last_err[ch]));
                    acc = longint'(integ_acc[ch]) + longint'(integ_gain) * e;
                    if (acc > mpsc_pkg::ACC_MAX) begin
                        acc = mpsc_pkg::ACC_MAX;
                    end else if (acc < mpsc_pkg::ACC_MIN) begin
                        acc = mpsc_pkg::ACC_MIN;
                    end
                    integ_acc[ch] = int'(acc);
                    last_err[ch]  = int'(e);
                    // asymmetric output limits: +1000 above, -999 below
                    sum = p + acc + d;
                    if (sum > mpsc_pkg::ACC_MAX) begin
                        sum = mpsc_pkg::SAT_HI;
                        saturated++;
                    end else if (sum < mpsc_pkg::ACC_MIN) begin
                        sum = mpsc_pkg::ACC_MIN;
                        saturated++;
                    end
                    if (sum < 0) begin
                        want.reverse = 1'b1;
                        sum = -sum;
                        reversed++;
                    end
                    want.magnitude = mpsc_pkg::MAG_W'(sum / FRAC_ONE);
                end
            end
            drive_q.push_back(want);
        endfunction

        function void check_drive(logic [mpsc_pkg::CH_W-1:0] ch, logic rev,
                                  logic [mpsc_pkg::MAG_W-1:0] mag);
            t_drive want;
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT) begin
                    $display("unexpected drive: ch %0d rev %0b mag %0d", ch, rev, mag);
                end
                return;
            end
            want = drive_q.pop_front();
            if (want.channel !== ch || want.reverse !== rev || want.magnitude !== mag) begin
                mismatches++;
                if (mismatches <= MAX_REPORT) begin
                    $display("drive mismatch: expected ch %0d rev %0b mag %0d,",
                             want.channel, want.reverse, want.magnitude,
                             " got ch %0d rev %0b mag %0d", ch, rev, mag);
                end
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

endpackage

### tb/tb_multichannel_pid_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_pid_speed_controller
// Self-checking bench: directed ticks at the field extremes, saturation,
// integral clamp, halt and small negative drive, then random control-loop
// traffic over several gain settings with random idling on both sides and
// a long receiver hold-off to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_multichannel_pid_speed_controller;

    localparam int CLK_HALF      = 10;
    localparam int RST_CYCLES    = 9;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS   = 215;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [mpsc_pkg::IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic [mpsc_pkg::CH_W-1:0]          i_channel;
    logic signed [mpsc_pkg::DATA_W-1:0] i_setpoint;
    logic signed [mpsc_pkg::DATA_W-1:0] i_measured;
    logic                               i_halt;
    logic                               o_valid;
    logic                               i_stall;
    logic [mpsc_pkg::CH_W-1:0]          o_channel_out;
    logic                               o_reverse;
    logic [mpsc_pkg::MAG_W-1:0]         o_magnitude;
    logic                               i_cfg_we;
    logic [mpsc_pkg::IDX_W-1:0]         i_cfg_idx;
    logic [mpsc_pkg::DATA_W-1:0]        i_cfg_data;

    mpsc_tb_pkg::pid_drive_scoreboard sb = new();

    int  cycle_count   = 0;
    int  stall_left    = 0;
    int  holdoffs      = 0;
    int  gain_settings = 0;
    int  errors;
    bit  no_idle       = 1'b0;
    bit  hold_req      = 1'b0;
    int  tgt_sp [mpsc_pkg::CHANNELS];

    multichannel_pid_speed_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_channel    (i_channel),
        .i_setpoint   (i_setpoint),
        .i_measured   (i_measured),
        .i_halt       (i_halt),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_channel_out(o_channel_out),
        .o_reverse    (o_reverse),
        .o_magnitude  (o_magnitude),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_multichannel_pid_speed_controller: done, errors");
            $finish;
        end
    end

    // mostly idle-free, with short gaps and the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver stall pattern, including the long hold-off on demand
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            i_stall    = 1'b1;
            holdoffs++;
        end else if (no_idle) begin
            i_stall = 1'b0;
        end else begin
            stall_left = idle_len();
            i_stall    = (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_drive(o_channel_out, o_reverse, o_magnitude);
        end
    end

    task automatic send_tick(input logic [mpsc_pkg::CH_W-1:0] ch,
                             input logic [mpsc_pkg::DATA_W-1:0] sp,
                             input logic [mpsc_pkg::DATA_W-1:0] pv, input logic halt);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_channel  = ch;
        i_setpoint = sp;
        i_measured = pv;
        i_halt     = halt;
        do @(posedge i_clk); while (o_stall);
        sb.note_tick(ch, sp, pv, halt);
    endtask

    // gains may only change once the pipeline is empty
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mpsc_pkg::IDX_W-1:0] idx,
                             input logic [mpsc_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_gain(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_gains(input logic [mpsc_pkg::DATA_W-1:0] kp,
                             input logic [mpsc_pkg::DATA_W-1:0] ki,
                             input logic [mpsc_pkg::DATA_W-1:0] kd);
        drain();
        write_reg(mpsc_pkg::REG_PROP_GAIN, kp);
        write_reg(mpsc_pkg::REG_INTEG_GAIN, ki);
        write_reg(mpsc_pkg::REG_DERIV_GAIN, kd);
        gain_settings++;
    endtask

    // speed loop traffic: measured hovers around a per-channel target,
    // with some full-range noise mixed in
    task automatic random_tick();
        logic [mpsc_pkg::CH_W-1:0] ch;
        int sp;
        int pv;
        int r;
        ch = mpsc_pkg::CH_W'($urandom_range(0, mpsc_pkg::CHANNELS - 1));
        r  = $urandom_range(0, 99);
        if (r < 3) tgt_sp[ch] = int'($urandom_range(0, 4000)) - 2000;
        if (r < 15) begin
            sp = $urandom;
            pv = $urandom;
        end else begin
            sp = tgt_sp[ch];
            pv = tgt_sp[ch] + int'($urandom_range(0, 400)) - 200;
        end
        send_tick(ch, mpsc_pkg::DATA_W'(sp), mpsc_pkg::DATA_W'(pv),
                  ($urandom_range(0, 49) == 0));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_channel  = '0;
        i_setpoint = '0;
        i_measured = '0;
        i_halt     = 1'b0;
        i_stall    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = mpsc_pkg::REG_PROP_GAIN;
        i_cfg_data = '0;
        foreach (tgt_sp[k]) tgt_sp[k] = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // gains still at reset: drive must be zero
        send_tick(2'd0, 16'h7FFF, 16'h8000, 1'b0);
        send_tick(2'd1, 16'h8000, 16'h7FFF, 1'b0);

        // smallest proportional gain: a tiny negative sum reverses with zero magnitude
        set_gains(16'h0001, 16'h0000, 16'h0000);
        write_reg(REG_SPARE, 16'hFFFF);
        send_tick(2'd2, 16'h0000, 16'h0001, 1'b0);
        send_tick(2'd3, 16'h0005, 16'h0005, 1'b0);
        send_tick(2'd0, 16'h7FFF, 16'h8000, 1'b0);
        send_tick(2'd1, 16'h8000, 16'h7FFF, 1'b0);

        // full gains: both saturation limits, halt and restart
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(2'd0, 16'h7FFF, 16'h8000, 1'b0);
        send_tick(2'd0, 16'h8000, 16'h7FFF, 1'b0);
        send_tick(2'd1, 16'h0000, 16'h0001, 1'b0);
        send_tick(2'd1, 16'h1234, 16'h4321, 1'b1);
        send_tick(2'd1, 16'h0000, 16'h0000, 1'b0);

        // integral alone, driven into both clamps
        set_gains(16'h0000, 16'h0010, 16'h0000);
        send_tick(2'd2, 16'd20000, -16'sd20000, 1'b0);
        send_tick(2'd2, -16'sd20000, 16'd20000, 1'b0);
        send_tick(2'd2, 16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(2'd2, 16'h0000, 16'h0000, 1'b0);

        // derivative alone, halting every channel
        set_gains(16'h0000, 16'h0000, 16'h0100);
        send_tick(2'd3, 16'd100, 16'd0, 1'b0);
        send_tick(2'd3, 16'd0, 16'd0, 1'b0);
        send_tick(2'd0, 16'h5555, 16'hAAAA, 1'b1);
        send_tick(2'd1, 16'hAAAA, 16'h5555, 1'b1);
        send_tick(2'd2, 16'h0000, 16'h0000, 1'b1);
        send_tick(2'd3, 16'hFFFF, 16'h0000, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_gains(mpsc_pkg::DATA_W'($urandom), mpsc_pkg::DATA_W'($urandom),
                             mpsc_pkg::DATA_W'($urandom));
                4: set_gains(16'h0100, 16'h0010, 16'h0080);
                5: set_gains(mpsc_pkg::DATA_W'($urandom_range(0, 16'h0200)),
                             mpsc_pkg::DATA_W'($urandom_range(0, 16'h0040)), 16'h0000);
                default: set_gains(mpsc_pkg::DATA_W'($urandom_range(0, 16'h0200)),
                                   mpsc_pkg::DATA_W'($urandom_range(0, 16'h0040)),
                                   mpsc_pkg::DATA_W'($urandom_range(0, 16'h0200)));
            endcase
            no_idle = (ph == 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // back-pressure: keep sending while the receiver sits still
                if ((ph == 2 || ph == 4) && n == 40) hold_req = 1'b1;
                random_tick();
            end
            no_idle = 1'b0;
        end

        drain();
        errors = sb.mismatches + sb.pending();
        $display("covered %0d control ticks (%0d halts) over %0d gain settings",
                 sb.ticks, sb.halts, gain_settings);
        $display("%0d drives saturated, %0d reversed, %0d long receiver hold-offs",
                 sb.saturated, sb.reversed, holdoffs);
        if (errors == 0) begin
            $display("tb_multichannel_pid_speed_controller: done, clean");
        end else begin
            $display("tb_multichannel_pid_speed_controller: done, errors");
        end
        $finish;
    end

endmodule

### multichannel_pid_speed_controller.f
rtl/mpsc_pkg.sv
rtl/mpsc_ram.sv
rtl/multichannel_pid_speed_controller.sv
tb/mpsc_tb_pkg.sv
tb/tb_multichannel_pid_speed_controller.sv
